@@ hw/rtl/mslfo_pkg.sv @@
// ----------------------------------------------------------------------------
// mslfo_pkg
// Shared types, constants and helper functions of the multi-shape LFO.
// ----------------------------------------------------------------------------
`default_nettype none

package mslfo_pkg;

    // Default build parameters
    localparam int PHASE_BITS_DEF  = 32;
    localparam int SAMPLE_BITS_DEF = 16;

    // Configuration port
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    localparam logic [2:0] REG_RATE_KNOB  = 3'd0;
    localparam logic [2:0] REG_CV_GAIN    = 3'd1;
    localparam logic [2:0] REG_FAST_RANGE = 3'd2;
    localparam logic [2:0] REG_WAVE_SHAPE = 3'd3;
    localparam logic [2:0] REG_DEPTH      = 3'd4;
    localparam logic [2:0] REG_UNIPOLAR   = 3'd5;
    localparam logic [2:0] REG_RECIPROCAL = 3'd6;

    localparam logic [31:0] RECIP_RESET = 32'd24933027;

    // Wave shape codes
    localparam logic [2:0] SHAPE_SINE     = 3'd0;
    localparam logic [2:0] SHAPE_TRIANGLE = 3'd1;
    localparam logic [2:0] SHAPE_SAW_UP   = 3'd2;
    localparam logic [2:0] SHAPE_SAW_DOWN = 3'd3;
    localparam logic [2:0] SHAPE_SQUARE   = 3'd4;
    localparam logic [2:0] SHAPE_RANDOM   = 3'd5;

    // Rate arithmetic
    localparam int RAW_W          = 36;
    localparam int ZERO_RATE_Q30  = 107374;
    localparam int ONE_Q30        = 1 << 30;
    localparam int SLOW_BASE_Q16  = 655;
    localparam int SLOW_SPAN_Q16  = 64881;
    localparam int FAST_BASE_Q16  = 327680;
    localparam int FREQ_W         = 21;

    // Random source
    localparam logic [15:0] LFSR_SEED = 16'hACE1;
    localparam logic [15:0] LFSR_TAPS = 16'hB400;

    // Shared bit-serial multiplier
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = FREQ_W;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    typedef struct packed {
        logic [16:0] rate_knob;
        logic [17:0] rate_cv_gain;
        logic        fast_range;
        logic [2:0]  wave_shape;
        logic [15:0] depth;
        logic        unipolar;
        logic [31:0] rate_reciprocal;
    } t_cfg;

    typedef struct packed {
        logic               start;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic               done;
        logic [MUL_P_W-1:0] prod;
    } t_mul_rsp;

    // One step of the right-shifting Galois LFSR
    function automatic logic [15:0] lfsr_next(input logic [15:0] v);
        logic [15:0] w;
        w = v >> 1;
        if (v[0]) begin
            w = w ^ LFSR_TAPS;
        end
        return w;
    endfunction

    // Map a bipolar shape value onto 0..32768
    function automatic logic signed [16:0] to_unipolar(input logic signed [16:0] s);
        logic signed [17:0] w;
        w = {s[16], s} + 18'sd32768;
        return w[17:1];
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/mslfo_regs.sv @@
// ----------------------------------------------------------------------------
// mslfo_regs
// APB-style register file holding the LFO configuration.
// ----------------------------------------------------------------------------
`default_nettype none

module mslfo_regs (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [mslfo_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [mslfo_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic      [mslfo_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                                   pready,
    output mslfo_pkg::t_cfg                        o_cfg
);

    mslfo_pkg::t_cfg r_cfg;
    logic [2:0]      reg_idx;
    logic            wr_en;

    assign reg_idx = paddr[mslfo_pkg::CFG_ADDR_W-1:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    // Write on the access phase of a transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rate_knob       <= '0;
            r_cfg.rate_cv_gain    <= '0;
            r_cfg.fast_range      <= 1'b0;
            r_cfg.wave_shape      <= mslfo_pkg::SHAPE_SINE;
            r_cfg.depth           <= '0;
            r_cfg.unipolar        <= 1'b0;
            r_cfg.rate_reciprocal <= mslfo_pkg::RECIP_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                mslfo_pkg::REG_RATE_KNOB:  r_cfg.rate_knob       <= pwdata[16:0];
                mslfo_pkg::REG_CV_GAIN:    r_cfg.rate_cv_gain    <= pwdata[17:0];
                mslfo_pkg::REG_FAST_RANGE: r_cfg.fast_range      <= pwdata[0];
                mslfo_pkg::REG_WAVE_SHAPE: r_cfg.wave_shape      <= pwdata[2:0];
                mslfo_pkg::REG_DEPTH:      r_cfg.depth           <= pwdata[15:0];
                mslfo_pkg::REG_UNIPOLAR:   r_cfg.unipolar        <= pwdata[0];
                mslfo_pkg::REG_RECIPROCAL: r_cfg.rate_reciprocal <= pwdata[31:0];
                default: begin
                end
            endcase
        end
    end

    // Read back
    always_comb begin
        case (reg_idx)
            mslfo_pkg::REG_RATE_KNOB:  prdata = 32'(r_cfg.rate_knob);
            mslfo_pkg::REG_CV_GAIN:    prdata = 32'(r_cfg.rate_cv_gain);
            mslfo_pkg::REG_FAST_RANGE: prdata = 32'(r_cfg.fast_range);
            mslfo_pkg::REG_WAVE_SHAPE: prdata = 32'(r_cfg.wave_shape);
            mslfo_pkg::REG_DEPTH:      prdata = 32'(r_cfg.depth);
            mslfo_pkg::REG_UNIPOLAR:   prdata = 32'(r_cfg.unipolar);
            mslfo_pkg::REG_RECIPROCAL: prdata = r_cfg.rate_reciprocal;
            default:                   prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/mslfo_mul.sv @@
// ----------------------------------------------------------------------------
// mslfo_mul
// Bit-serial unsigned shift-add multiplier, one multiplier bit per clock.
// ----------------------------------------------------------------------------
`default_nettype none

module mslfo_mul (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire mslfo_pkg::t_mul_req i_req,
    output mslfo_pkg::t_mul_rsp     o_rsp
);

    logic [mslfo_pkg::MUL_P_W-1:0] r_a;
    logic [mslfo_pkg::MUL_P_W-1:0] r_acc;
    logic [mslfo_pkg::MUL_B_W-1:0] r_b;
    logic                          r_busy;

    // Finished once every set multiplier bit has been consumed
    assign o_rsp.done = r_busy && (r_b == '0);
    assign o_rsp.prod = r_acc;

    // Shift the multiplicand up and the multiplier down, add on a set bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_a    <= mslfo_pkg::MUL_P_W'(i_req.a);
            r_b    <= i_req.b;
            r_acc  <= '0;
        end else if (r_busy) begin
            if (r_b == '0) begin
                r_busy <= 1'b0;
            end else begin
                if (r_b[0]) begin
                    r_acc <= r_acc + r_a;
                end
                r_a <= r_a << 1;
                r_b <= r_b >> 1;
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/multi_shape_lfo_core.sv @@
// ----------------------------------------------------------------------------
// multi_shape_lfo_core
// Multi-shape LFO: rate from knob and CV, phase accumulator, six wave shapes.
// ----------------------------------------------------------------------------
// One item is taken per sample tick and gives one output level. The time an
// item occupies the block, from one input transfer to the next, depends on the
// operand values: every product (CV times attenuverter, slow-range mapping,
// frequency times reciprocal, the parabolic sine and the depth scaling) runs on
// one shared bit-serial multiplier that consumes one multiplier bit per clock
// and finishes once its highest set bit is consumed. The longest case is the
// slow range with the sine shape and full-scale operands, the shortest a
// stopped random level with no CV. The input stalls while an item is in work; a
// finished level waits in the output register, and the next item may be taken
// while it does. That item then holds in its last state until the output
// register frees.
`default_nettype none

module multi_shape_lfo_core #(
    parameter int PHASE_BITS  = mslfo_pkg::PHASE_BITS_DEF,
    parameter int SAMPLE_BITS = mslfo_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // configuration port
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [mslfo_pkg::CFG_ADDR_W-1:0]     paddr,
    input  wire logic [mslfo_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic      [mslfo_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                      pready,
    // input channel
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_stall,
    input  wire logic                                 i_gate_high,
    input  wire logic                                 i_reset_high,
    input  wire logic signed [15:0]                   i_rate_cv,
    input  wire logic                                 i_cv_present,
    // output channel
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_stall,
    output logic signed [SAMPLE_BITS-1:0]             o_lfo_level
);

    localparam int STEP_SHIFT = 56 - PHASE_BITS;
    localparam int WIDE_W     = 31 + SAMPLE_BITS;
    localparam logic [WIDE_W:0] ROUND_HALF = (WIDE_W + 1)'(64'd1 << 30);

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_MCV   = 13'b0000000000010,
        S_RATE  = 13'b0000000000100,
        S_CLAMP = 13'b0000000001000,
        S_MFQ   = 13'b0000000010000,
        S_FREQ  = 13'b0000000100000,
        S_MST   = 13'b0000001000000,
        S_ADV   = 13'b0000010000000,
        S_SHAPE = 13'b0000100000000,
        S_MSIN  = 13'b0001000000000,
        S_SCALE = 13'b0010000000000,
        S_MSC   = 13'b0100000000000,
        S_OUT   = 13'b1000000000000
    } t_state;

    mslfo_pkg::t_cfg     cfg;
    mslfo_pkg::t_mul_req mul_req;
    mslfo_pkg::t_mul_rsp mul_rsp;

    t_state                        r_state, n_state;
    logic [PHASE_BITS-1:0]         r_phase, n_phase;
    logic [15:0]                   r_rand, n_rand;
    logic [15:0]                   r_lfsr, n_lfsr;
    logic                          r_gate_before, n_gate_before;
    logic                          r_reset_before, n_reset_before;
    logic                          r_gate_rise, n_gate_rise;
    logic                          r_neg, n_neg;
    logic signed [mslfo_pkg::RAW_W-1:0] r_raw, n_raw;
    logic [16:0]                   r_m, n_m;
    logic signed [16:0]            r_s, n_s;
    logic [WIDE_W-1:0]             r_wide, n_wide;
    logic                          r_out_valid, n_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out, n_out;

    // Per-state working values
    logic signed [15:0]            cv_eff;
    logic [15:0]                   cv_abs;
    logic [17:0]                   gain_abs;
    logic [33:0]                   cv_prod;
    logic signed [mslfo_pkg::RAW_W-1:0] cv_term;
    logic                          is_rand;
    logic [32:0]                   slow_sum;
    logic [mslfo_pkg::FREQ_W-1:0]  freq;
    logic [PHASE_BITS-1:0]         step;
    logic [PHASE_BITS:0]           phase_sum;
    logic [15:0]                   t_top;
    logic signed [15:0]            x_val;
    logic [15:0]                   x_abs;
    logic [16:0]                   sine_comp;
    logic signed [17:0]            tri_wide;
    logic signed [16:0]            shape_s;
    logic signed [16:0]            sine_mag;
    logic [16:0]                   s_abs;
    logic [31:0]                   scale_prod;
    logic [WIDE_W:0]               rounded;
    logic [SAMPLE_BITS-1:0]        out_mag;

    mslfo_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    mslfo_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_lfo_level = r_out;

    // Operand preparation, shared by several states
    always_comb begin
        cv_eff    = i_cv_present ? i_rate_cv : 16'sd0;
        cv_abs    = cv_eff[15] ? 16'(-cv_eff) : 16'(cv_eff);
        gain_abs  = cfg.rate_cv_gain[17] ? 18'(-cfg.rate_cv_gain) : cfg.rate_cv_gain;
        cv_prod   = mul_rsp.prod[33:0];
        cv_term   = r_neg ? -$signed({2'b00, cv_prod}) : $signed({2'b00, cv_prod});
        is_rand   = (cfg.wave_shape == mslfo_pkg::SHAPE_RANDOM);
        slow_sum  = mul_rsp.prod[32:0] + 33'd32768;
        step      = PHASE_BITS'(mul_rsp.prod >> STEP_SHIFT);
        phase_sum = {1'b0, r_phase} + {1'b0, step};
        t_top     = r_phase[PHASE_BITS-1 -: 16];
        x_val     = $signed({~t_top[15], t_top[14:0]});
        x_abs     = x_val[15] ? 16'(-x_val) : 16'(x_val);
        sine_comp = 17'd32768 - {1'b0, x_abs};
        sine_mag  = $signed({1'b0, mul_rsp.prod[28:13]});
        s_abs     = r_s[16] ? 17'(-r_s) : 17'(r_s);
        scale_prod = mul_rsp.prod[31:0];
        rounded   = {1'b0, r_wide} + ROUND_HALF;
        out_mag   = rounded[30+SAMPLE_BITS:31];

        // Slow range from the mapping product, fast range as shifts and adds
        if (cfg.fast_range) begin
            freq = mslfo_pkg::FREQ_W'(mslfo_pkg::FAST_BASE_Q16) + {r_m, 4'b0000}
                 + {3'b000, r_m, 1'b0} + {4'b0000, r_m};
        end else begin
            freq = mslfo_pkg::FREQ_W'(mslfo_pkg::SLOW_BASE_Q16)
                 + mslfo_pkg::FREQ_W'(slow_sum[32:16]);
        end

        // Shape value from the top phase bits
        tri_wide = t_top[15] ? (18'sd98304 - $signed({1'b0, t_top, 1'b0}))
                             : ($signed({1'b0, t_top, 1'b0}) - 18'sd32768);
        case (cfg.wave_shape)
            mslfo_pkg::SHAPE_TRIANGLE: shape_s = tri_wide[16:0];
            mslfo_pkg::SHAPE_SAW_UP:   shape_s = {x_val[15], x_val};
            mslfo_pkg::SHAPE_SAW_DOWN: shape_s = -{x_val[15], x_val};
            mslfo_pkg::SHAPE_SQUARE:   shape_s = t_top[15] ? -17'sd32768 : 17'sd32768;
            mslfo_pkg::SHAPE_RANDOM:   shape_s = $signed({r_rand[15], r_rand});
            default:                   shape_s = 17'sd0;
        endcase
    end

    // Sequencer and datapath next values
    always_comb begin
        n_state        = r_state;
        n_phase        = r_phase;
        n_rand         = r_rand;
        n_lfsr         = r_lfsr;
        n_gate_before  = r_gate_before;
        n_reset_before = r_reset_before;
        n_gate_rise    = r_gate_rise;
        n_neg          = r_neg;
        n_raw          = r_raw;
        n_m            = r_m;
        n_s            = r_s;
        n_wide         = r_wide;
        n_out          = r_out;
        n_out_valid    = r_out_valid;
        mul_req.start  = 1'b0;
        mul_req.a      = '0;
        mul_req.b      = '0;

        // Drop the output once it is taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_gate_rise    = i_gate_high & ~r_gate_before;
                    n_gate_before  = i_gate_high;
                    n_reset_before = i_reset_high;
                    if (i_reset_high && !r_reset_before) begin
                        n_phase = '0;
                    end
                    n_neg         = cv_eff[15] ^ cfg.rate_cv_gain[17];
                    mul_req.start = 1'b1;
                    mul_req.a     = mslfo_pkg::MUL_A_W'(gain_abs);
                    mul_req.b     = mslfo_pkg::MUL_B_W'(cv_abs);
                    n_state       = S_MCV;
                end
            end
            S_MCV: begin
                if (mul_rsp.done) begin
                    n_state = S_RATE;
                end
            end
            S_RATE: begin
                n_raw   = $signed({5'b00000, cfg.rate_knob, 14'b0}) + cv_term;
                n_state = S_CLAMP;
            end
            S_CLAMP: begin
                // Clamp the rate to 0..1 and keep it in Q16
                if (r_raw[mslfo_pkg::RAW_W-1]) begin
                    n_m = '0;
                end else if (r_raw > $signed(mslfo_pkg::RAW_W'(mslfo_pkg::ONE_Q30))) begin
                    n_m = 17'h10000;
                end else begin
                    n_m = r_raw[30:14];
                end
                if (is_rand && (r_raw <= $signed(mslfo_pkg::RAW_W'(mslfo_pkg::ZERO_RATE_Q30))))
                begin
                    // Stopped random: hold the phase, draw on a gate rising edge
                    if (r_gate_rise) begin
                        n_lfsr = mslfo_pkg::lfsr_next(r_lfsr);
                        n_rand = n_lfsr;
                    end
                    n_state = S_SHAPE;
                end else if (cfg.fast_range) begin
                    n_state = S_FREQ;
                end else begin
                    mul_req.start = 1'b1;
                    mul_req.a     = mslfo_pkg::MUL_A_W'(n_m);
                    mul_req.b     = mslfo_pkg::MUL_B_W'(mslfo_pkg::SLOW_SPAN_Q16);
                    n_state       = S_MFQ;
                end
            end
            S_MFQ: begin
                if (mul_rsp.done) begin
                    n_state = S_FREQ;
                end
            end
            S_FREQ: begin
                mul_req.start = 1'b1;
                mul_req.a     = cfg.rate_reciprocal;
                mul_req.b     = freq;
                n_state       = S_MST;
            end
            S_MST: begin
                if (mul_rsp.done) begin
                    n_state = S_ADV;
                end
            end
            S_ADV: begin
                // Advance the phase, draw a new random level on wrap
                n_phase = phase_sum[PHASE_BITS-1:0];
                if (phase_sum[PHASE_BITS] && is_rand) begin
                    n_lfsr = mslfo_pkg::lfsr_next(r_lfsr);
                    n_rand = n_lfsr;
                end
                n_state = S_SHAPE;
            end
            S_SHAPE: begin
                if (cfg.wave_shape == mslfo_pkg::SHAPE_SINE) begin
                    n_neg         = x_val[15];
                    mul_req.start = 1'b1;
                    mul_req.a     = mslfo_pkg::MUL_A_W'(sine_comp);
                    mul_req.b     = mslfo_pkg::MUL_B_W'(x_abs);
                    n_state       = S_MSIN;
                end else begin
                    n_s     = cfg.unipolar ? mslfo_pkg::to_unipolar(shape_s) : shape_s;
                    n_state = S_SCALE;
                end
            end
            S_MSIN: begin
                if (mul_rsp.done) begin
                    n_s = r_neg ? -sine_mag : sine_mag;
                    if (cfg.unipolar) begin
                        n_s = mslfo_pkg::to_unipolar(n_s);
                    end
                    n_state = S_SCALE;
                end
            end
            S_SCALE: begin
                n_neg         = r_s[16];
                mul_req.start = 1'b1;
                mul_req.a     = mslfo_pkg::MUL_A_W'(cfg.depth);
                mul_req.b     = mslfo_pkg::MUL_B_W'(s_abs[15:0]);
                n_state       = S_MSC;
            end
            S_MSC: begin
                // Times full scale, as a shift and a subtract
                if (mul_rsp.done) begin
                    n_wide  = (WIDE_W'(scale_prod) << (SAMPLE_BITS - 1)) - WIDE_W'(scale_prod);
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                // Round half away from zero and hand over to the output register
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = r_neg ? -$signed(out_mag) : $signed(out_mag);
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_phase        <= '0;
            r_rand         <= '0;
            r_lfsr         <= mslfo_pkg::LFSR_SEED;
            r_gate_before  <= 1'b0;
            r_reset_before <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_phase        <= n_phase;
            r_rand         <= n_rand;
            r_lfsr         <= n_lfsr;
            r_gate_before  <= n_gate_before;
            r_reset_before <= n_reset_before;
            r_out_valid    <= n_out_valid;
        end
    end

    // Working registers, no reset
    always_ff @(posedge i_clk) begin
        r_gate_rise <= n_gate_rise;
        r_neg       <= n_neg;
        r_raw       <= n_raw;
        r_m         <= n_m;
        r_s         <= n_s;
        r_wide      <= n_wide;
        r_out       <= n_out;
    end

endmodule

`default_nettype wire
